[design/prt_pkg.sv]
// Shared types, constants and tables of the planar rigid transform unit.
`timescale 1ns / 1ps
`default_nettype none

package prt_pkg;

  // Default build parameters
  localparam int FracBitsDefault = 16;
  localparam int CordicStepsDefault = 16;
  localparam int AtanEntries = 30;

  // Rounded rotation result and widened sum widths
  localparam int ResW = 35;
  localparam int SumW = 36;

  // CORDIC gain 1/K in Q1.30
  localparam logic signed [30:0] GainQ30 = 31'sd652032874;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_COMPOSE = 3'd1,
    OP_MAP_PT  = 3'd2,
    OP_MAP_TW  = 3'd3,
    OP_INVERSE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_DONE
  } prt_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MUL_X,
    CS_MUL_Y,
    CS_ITER
  } cor_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] angle;
  } rot_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [ResW-1:0] x;
    logic signed [ResW-1:0] y;
  } rot_rsp_t;

  typedef struct packed {
    logic        flag;
    logic [31:0] val;
  } sat_t;

  // Binary-angle arctangent of 2^-idx, full turn is 2^32
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] r;
    unique case (idx)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051D;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2E;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2F9;
      5'd15: r = 30'h0000517C;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A2F;
      5'd19: r = 30'h00000517;
      5'd20: r = 30'h0000028B;
      5'd21: r = 30'h00000145;
      5'd22: r = 30'h000000A2;
      5'd23: r = 30'h00000051;
      5'd24: r = 30'h00000028;
      5'd25: r = 30'h00000014;
      5'd26: r = 30'h0000000A;
      5'd27: r = 30'h00000005;
      5'd28: r = 30'h00000002;
      5'd29: r = 30'h00000001;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

  // Clip a widened sum to the signed 32-bit range
  function automatic sat_t sat32(input logic signed [SumW-1:0] v);
    sat_t r;
    if (v > SumW'(32'sh7FFFFFFF)) begin
      r.flag = 1'b1;
      r.val  = 32'h7FFFFFFF;
    end else if (v < SumW'(-64'sh80000000)) begin
      r.flag = 1'b1;
      r.val  = 32'h80000000;
    end else begin
      r.flag = 1'b0;
      r.val  = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/prt_cordic.sv]
// Iterative CORDIC rotator: gain multiply, then one shift-add step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module prt_cordic
  import prt_pkg::*;
#(
  parameter int FRAC_BITS    = FracBitsDefault,
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire rot_req_t req_i,
  output rot_rsp_t      rsp_o
);

  localparam int W     = 32 + FRAC_BITS + 3;
  localparam int ZW    = 34;
  localparam int MulW  = 64;
  localparam int GSh   = 30 - FRAC_BITS;
  localparam int NStep = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
  localparam int IW    = $clog2(NStep);
  localparam logic [IW-1:0] LastIdx = IW'(NStep - 1);
  localparam logic signed [W-1:0] Half =
    {{(W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  localparam logic signed [ZW-1:0] Quarter = ZW'(64'sh40000000);
  localparam logic signed [ZW-1:0] HalfTurn = ZW'(64'sh80000000);

  cor_state_e state_q, state_d;

  logic signed [32:0]   vx_q, vy_q;
  logic signed [ZW-1:0] z_q;
  logic signed [W-1:0]  x_q, y_q;
  logic [IW-1:0]        cnt_q;

  // Pre-rotation by a half turn when the heading lies beyond a quarter turn
  logic signed [ZW-1:0] z_in;
  logic signed [32:0]   vx_in, vy_in;
  logic signed [ZW-1:0] z_pre;
  logic signed [32:0]   vx_pre, vy_pre;

  always_comb begin
    z_in  = ZW'($signed(req_i.angle));
    vx_in = 33'($signed(req_i.x));
    vy_in = 33'($signed(req_i.y));
    if (z_in > Quarter) begin
      z_pre  = z_in - HalfTurn;
      vx_pre = -vx_in;
      vy_pre = -vy_in;
    end else if (z_in < -Quarter) begin
      z_pre  = z_in + HalfTurn;
      vx_pre = -vx_in;
      vy_pre = -vy_in;
    end else begin
      z_pre  = z_in;
      vx_pre = vx_in;
      vy_pre = vy_in;
    end
  end

  // Shared gain multiplier, x then y
  logic signed [32:0]   mul_a;
  logic signed [MulW-1:0] prod;
  logic signed [MulW-1:0] prod_sh;
  logic signed [W-1:0]  scaled;

  assign mul_a   = (state_q == CS_MUL_Y) ? vy_q : vx_q;
  assign prod    = MulW'(mul_a) * MulW'(GainQ30);
  assign prod_sh = prod >>> GSh;
  assign scaled  = prod_sh[W-1:0];

  // Shift-add step
  logic signed [W-1:0]  dx, dy;
  logic signed [ZW-1:0] atan_z;
  logic                 last;
  logic                 rot_done;

  assign dx     = y_q >>> cnt_q;
  assign dy     = x_q >>> cnt_q;
  assign atan_z = $signed({{(ZW - 30){1'b0}}, atan_entry(5'(cnt_q))});
  assign last   = (cnt_q == LastIdx);

  always_comb begin
    state_d  = state_q;
    rot_done = 1'b0;
    unique case (state_q)
      CS_IDLE: begin
        if (req_i.start) state_d = CS_MUL_X;
      end
      CS_MUL_X: state_d = CS_MUL_Y;
      CS_MUL_Y: state_d = CS_ITER;
      CS_ITER: begin
        if (last) begin
          state_d  = CS_IDLE;
          rot_done = 1'b1;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      CS_IDLE: begin
        if (req_i.start) begin
          vx_q <= vx_pre;
          vy_q <= vy_pre;
          z_q  <= z_pre;
        end
      end
      CS_MUL_X: x_q <= scaled;
      CS_MUL_Y: begin
        y_q   <= scaled;
        cnt_q <= '0;
      end
      CS_ITER: begin
        if (!z_q[ZW-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_z;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_z;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      default: ;
    endcase
  end

  // Round to nearest, dropping the guard bits
  logic signed [W-1:0] xr, yr;
  assign xr    = x_q + Half;
  assign yr    = y_q + Half;
  assign rsp_o = {rot_done, xr[W-1:FRAC_BITS], yr[W-1:FRAC_BITS]};

endmodule

`default_nettype wire

[design/planar_rigid_transform_unit.sv]
// Top level of the planar rigid transform unit: pose state, sequencer, output register.
//
// Usage:
//   Input channel s_axis: one transaction per command. tuser carries the opcode
//   (load, compose, map point, map twist, report inverse); tdata carries
//   x, y, angle and rate from the lowest bit up, each 32 bits.
//   Output channel m_axis: exactly one transaction per command, tdata holding
//   x, y, angle and rate, tuser holding the saturation flag.
// Sequence:
//   Rotating commands (compose, map point, map twist, report inverse) pass two
//   gain-multiply steps, CORDIC_STEPS shift-add steps (capped at 30) and one
//   finish step, which waits while the output register holds an untaken result.
//   The next command is taken once the finish step is done, so one command is
//   processed at a time; the single CORDIC shift-add stage dominates the time
//   per command. Load and unknown opcodes go straight to the finish step.
// Reset: pose and heading clear to zero, both channels go idle.
// Stall: a result waits in the output register; one further command is
//   accepted meanwhile and holds in its finish step until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module planar_rigid_transform_unit
  import prt_pkg::*;
#(
  parameter int FRAC_BITS    = FracBitsDefault,
  parameter int CORDIC_STEPS = CordicStepsDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // in_x, in_y, in_angle, in_rate
  input  wire logic [2:0]   s_axis_tuser,  // opcode
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [127:0]      m_axis_tdata,  // out_x, out_y, out_angle, out_rate
  output logic [0:0]        m_axis_tuser   // saturated
);

  prt_state_e state_q, state_d;

  // Pose held between commands
  logic [31:0] pose_x_q, pose_x_d;
  logic [31:0] pose_y_q, pose_y_d;
  logic [31:0] heading_q, heading_d;

  // Command captured at accept
  op_e         op_q;
  logic [31:0] vx_q, vy_q, ang_q, rate_q;

  // Output register
  logic        m_valid_q;
  logic [31:0] ox_q, oy_q, oa_q, orate_q;
  logic        osat_q;
  logic [31:0] ox_d, oy_d, oa_d, orate_d;
  logic        osat_d;

  logic     accept;
  logic     finish;
  op_e      in_op;
  logic     in_rot;
  rot_req_t rot_req;
  rot_rsp_t rot_rsp;

  assign in_op  = op_e'(s_axis_tuser);
  assign in_rot = (in_op == OP_COMPOSE) || (in_op == OP_MAP_PT) ||
                  (in_op == OP_MAP_TW) || (in_op == OP_INVERSE);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  // Report inverse rotates the pose by the negated heading; others the input vector
  always_comb begin
    rot_req.start = accept && in_rot;
    if (in_op == OP_INVERSE) begin
      rot_req.x     = pose_x_q;
      rot_req.y     = pose_y_q;
      rot_req.angle = 32'd0 - heading_q;
    end else begin
      rot_req.x     = s_axis_tdata[31:0];
      rot_req.y     = s_axis_tdata[63:32];
      rot_req.angle = heading_q;
    end
  end

  prt_cordic #(
    .FRAC_BITS   (FRAC_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (rot_req),
    .rsp_o (rot_rsp)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    finish  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = in_rot ? ST_ROT : ST_DONE;
      end
      ST_ROT: begin
        if (rot_rsp.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Finish step: add translation for compose and map point, clip, form the answer
  logic signed [SumW-1:0] rx_w, ry_w;
  sat_t sx, sy;

  always_comb begin
    rx_w      = SumW'(rot_rsp.x);
    ry_w      = SumW'(rot_rsp.y);
    pose_x_d  = pose_x_q;
    pose_y_d  = pose_y_q;
    heading_d = heading_q;
    ox_d      = pose_x_q;
    oy_d      = pose_y_q;
    oa_d      = heading_q;
    orate_d   = '0;
    osat_d    = 1'b0;
    sx        = '0;
    sy        = '0;
    unique case (op_q)
      OP_LOAD: begin
        pose_x_d  = vx_q;
        pose_y_d  = vy_q;
        heading_d = ang_q;
        ox_d      = vx_q;
        oy_d      = vy_q;
        oa_d      = ang_q;
      end
      OP_COMPOSE, OP_MAP_PT: begin
        sx     = sat32(SumW'($signed(pose_x_q)) + rx_w);
        sy     = sat32(SumW'($signed(pose_y_q)) + ry_w);
        ox_d   = sx.val;
        oy_d   = sy.val;
        osat_d = sx.flag | sy.flag;
        if (op_q == OP_COMPOSE) begin
          pose_x_d  = sx.val;
          pose_y_d  = sy.val;
          heading_d = heading_q + ang_q;
          oa_d      = heading_q + ang_q;
        end
      end
      OP_MAP_TW: begin
        sx      = sat32(rx_w);
        sy      = sat32(ry_w);
        ox_d    = sx.val;
        oy_d    = sy.val;
        orate_d = rate_q;
        osat_d  = sx.flag | sy.flag;
      end
      OP_INVERSE: begin
        sx     = sat32(-rx_w);
        sy     = sat32(-ry_w);
        ox_d   = sx.val;
        oy_d   = sy.val;
        oa_d   = 32'd0 - heading_q;
        osat_d = sx.flag | sy.flag;
      end
      default: ;  // unused opcodes answer the current pose
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      pose_x_q  <= '0;
      pose_y_q  <= '0;
      heading_q <= '0;
    end else begin
      state_q <= state_d;
      if (finish) begin
        m_valid_q <= 1'b1;
        pose_x_q  <= pose_x_d;
        pose_y_q  <= pose_y_d;
        heading_q <= heading_d;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Capture the command and load the result; payload carries no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_op;
      vx_q   <= s_axis_tdata[31:0];
      vy_q   <= s_axis_tdata[63:32];
      ang_q  <= s_axis_tdata[95:64];
      rate_q <= s_axis_tdata[127:96];
    end
    if (finish) begin
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      oa_q    <= oa_d;
      orate_q <= orate_d;
      osat_q  <= osat_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {orate_q, oa_q, oy_q, ox_q};
  assign m_axis_tuser  = osat_q;

endmodule

`default_nettype wire

[design/prt_checker.sv]
// Port-level checker for the planar rigid transform unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module prt_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [127:0] m_axis_tdata,
  input wire logic [0:0]   m_axis_tuser
);

  // One command at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a command was in flight");

  // A new result only appears as a command finishes, never while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result raised without a command in progress");

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result payload changed while stalled");

endmodule

bind planar_rigid_transform_unit prt_checker u_prt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

[dv/tb_planar_rigid_transform_unit.sv]
// Self-checking testbench of the planar rigid transform unit: directed table then random commands.
`timescale 1ns / 1ps

module tb_planar_rigid_transform_unit;
  import prt_pkg::*;

  localparam int FracBits    = 16;
  localparam int CordicSteps = 16;
  localparam longint CordicGain = 64'sd652032874;
  localparam int RandomCmds  = 1625;
  localparam int MaxGap      = 16;

  // opcodes with no operation behind them
  localparam logic [2:0] OpUnusedLo  = 3'd5;
  localparam logic [2:0] OpUnusedMid = 3'd6;
  localparam logic [2:0] OpUnusedHi  = 3'd7;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] angle;
    logic [31:0] rate;
    logic        sat;
  } pose_answer_t;

  typedef struct {
    logic [2:0]   op;
    logic [31:0]  x;
    logic [31:0]  y;
    logic [31:0]  angle;
    logic [31:0]  rate;
    bit           typed;
    pose_answer_t want;
  } cmd_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  // tracked pose of the block
  longint      trk_x;
  longint      trk_y;
  logic [31:0] trk_heading;

  pose_answer_t answers_due[$];
  cmd_row_t     cmd_table[$];
  int           mismatches = 0;
  bit           steady_flow = 1'b0;
  int           out_hold = 0;

  longint atan_lut [30] = '{
    64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
  };

  planar_rigid_transform_unit #(
    .FRAC_BITS   (FracBits),
    .CORDIC_STEPS(CordicSteps)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Rotate a vector by a binary angle with the block's CORDIC arithmetic.
  function automatic void cordic_rotate(input longint vx, input longint vy,
                                        input logic [31:0] ang,
                                        output longint rx, output longint ry);
    longint z;
    longint x;
    longint y;
    longint dx;
    longint dy;
    z = longint'($signed(ang));
    // fold angles beyond a quarter turn by a half turn
    if (z > 64'sh40000000) begin
      vx = -vx; vy = -vy; z = z - 64'sh80000000;
    end else if (z < -64'sh40000000) begin
      vx = -vx; vy = -vy; z = z + 64'sh80000000;
    end
    x = (vx * CordicGain) >>> (30 - FracBits);
    y = (vy * CordicGain) >>> (30 - FracBits);
    for (int i = 0; i < CordicSteps && i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_lut[i];
      end else begin
        x = x + dx; y = y - dy; z = z + atan_lut[i];
      end
    end
    rx = (x + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
    ry = (y + (64'sd1 <<< (FracBits - 1))) >>> FracBits;
  endfunction

  function automatic longint clip32(input longint v, inout logic flag);
    if (v > 64'sh7FFFFFFF) begin
      flag = 1'b1;
      return 64'sh7FFFFFFF;
    end
    if (v < -64'sh80000000) begin
      flag = 1'b1;
      return -64'sh80000000;
    end
    return v;
  endfunction

  // Work out the answer to one command and advance the tracked pose.
  function automatic pose_answer_t predict_answer(input logic [2:0] op,
                                                  input logic [31:0] ix,
                                                  input logic [31:0] iy,
                                                  input logic [31:0] ia,
                                                  input logic [31:0] ir);
    pose_answer_t a;
    longint vx;
    longint vy;
    longint rx;
    longint ry;
    longint ox;
    longint oy;
    logic   flag;
    vx = longint'($signed(ix));
    vy = longint'($signed(iy));
    ox = trk_x;
    oy = trk_y;
    flag = 1'b0;
    a.angle = trk_heading;
    a.rate = '0;
    case (op)
      OP_LOAD: begin
        trk_x = vx; trk_y = vy; trk_heading = ia;
        ox = vx; oy = vy; a.angle = ia;
      end
      OP_COMPOSE: begin
        cordic_rotate(vx, vy, trk_heading, rx, ry);
        trk_x = clip32(trk_x + rx, flag);
        trk_y = clip32(trk_y + ry, flag);
        trk_heading = trk_heading + ia;
        ox = trk_x; oy = trk_y; a.angle = trk_heading;
      end
      OP_MAP_PT: begin
        cordic_rotate(vx, vy, trk_heading, rx, ry);
        ox = clip32(trk_x + rx, flag);
        oy = clip32(trk_y + ry, flag);
      end
      OP_MAP_TW: begin
        cordic_rotate(vx, vy, trk_heading, rx, ry);
        ox = clip32(rx, flag);
        oy = clip32(ry, flag);
        a.rate = ir;
      end
      OP_INVERSE: begin
        a.angle = 32'd0 - trk_heading;
        cordic_rotate(trk_x, trk_y, a.angle, rx, ry);
        ox = clip32(-rx, flag);
        oy = clip32(-ry, flag);
      end
      default: begin
      end
    endcase
    a.x = ox[31:0];
    a.y = oy[31:0];
    a.sat = flag;
    return a;
  endfunction

  task automatic add_row(input logic [2:0] op, input logic [31:0] x, input logic [31:0] y,
                         input logic [31:0] ang, input logic [31:0] rate, input bit typed,
                         input logic [31:0] wx = '0, input logic [31:0] wy = '0,
                         input logic [31:0] wa = '0, input logic sat = 1'b0);
    cmd_row_t r;
    r.op = op; r.x = x; r.y = y; r.angle = ang; r.rate = rate;
    r.typed = typed;
    r.want.x = wx; r.want.y = wy; r.want.angle = wa;
    r.want.rate = '0; r.want.sat = sat;
    cmd_table.push_back(r);
  endtask

  // Present one command after a random gap, none while flow is steady, and hold it until accepted.
  task automatic send_cmd(input cmd_row_t r);
    int gap;
    pose_answer_t p;
    gap = steady_flow ? 0 : $urandom_range(0, MaxGap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.rate, r.angle, r.y, r.x};
    s_axis_tuser  <= r.op;
    do @(posedge clk_i); while (!s_axis_tready);
    p = predict_answer(r.op, r.x, r.y, r.angle, r.rate);
    answers_due.push_back(r.typed ? r.want : p);
  endtask

  function automatic logic [31:0] pick_coord();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 32'h7FFFFFFF;
          1: v = 32'h80000000;
          2: v = 32'hFFFFFFFF;
          default: v = 32'h00000000;
        endcase
      end
      1, 2: v = $urandom;
      default: v = 32'($signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000);
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_angle();
    logic [31:0] v;
    case ($urandom_range(0, 11))
      0: v = 32'h40000000;
      1: v = 32'h40000001;
      2: v = 32'hC0000000;
      3: v = 32'hBFFFFFFF;
      4: v = 32'h80000000;
      5: v = 32'h00000000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] pick_op();
    logic [2:0] op;
    int w;
    w = $urandom_range(0, 99);
    if (w < 14)      op = OP_LOAD;
    else if (w < 40) op = OP_COMPOSE;
    else if (w < 62) op = OP_MAP_PT;
    else if (w < 82) op = OP_MAP_TW;
    else if (w < 94) op = OP_INVERSE;
    else begin
      case ($urandom_range(0, 2))
        0: op = OpUnusedLo;
        1: op = OpUnusedMid;
        default: op = OpUnusedHi;
      endcase
    end
    return op;
  endfunction

  // Accept results with random stalls, none while flow is steady, and check them in order.
  always @(posedge clk_i) begin
    pose_answer_t want;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] ga;
    logic [31:0] gr;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        {gr, ga, gy, gx} = m_axis_tdata;
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing expected: x=%h y=%h angle=%h rate=%h sat=%b",
                     $realtime, gx, gy, ga, gr, m_axis_tuser[0]);
        end else begin
          want = answers_due.pop_front();
          if (gx !== want.x || gy !== want.y || ga !== want.angle ||
              gr !== want.rate || m_axis_tuser[0] !== want.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp x=%h y=%h angle=%h rate=%h sat=%b, got x=%h y=%h angle=%h rate=%h sat=%b",
                       $realtime, want.x, want.y, want.angle, want.rate, want.sat,
                       gx, gy, ga, gr, m_axis_tuser[0]);
          end
        end
        out_hold = steady_flow ? 0 : $urandom_range(0, MaxGap);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      m_axis_tready <= (out_hold == 0);
    end
  end

  initial begin
    cmd_row_t r;
    // after reset the pose is all zero
    add_row(OP_INVERSE, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hFFFFFFFF, 1'b1);
    add_row(OpUnusedLo, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1);
    add_row(OP_MAP_TW, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h7FFFFFFF, 1'b0);
    // extreme load, echoed back
    add_row(OP_LOAD, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h55555555, 1'b1,
            32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    add_row(OpUnusedMid, 32'h0, 32'h0, 32'h0, 32'hAAAAAAAA, 1'b1,
            32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    add_row(OP_INVERSE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    add_row(OP_MAP_PT, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 1'b0);
    add_row(OP_MAP_TW, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h80000000, 1'b0);
    // both coordinates clip high on compose
    add_row(OP_LOAD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b1,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0);
    add_row(OP_COMPOSE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b1,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h0, 1'b1);
    // headings on and just past the quarter and half turn folds
    add_row(OP_LOAD, 32'h0, 32'h0, 32'h40000000, 32'h0, 1'b1, 32'h0, 32'h0, 32'h40000000);
    add_row(OP_MAP_PT, 32'h00010000, 32'h0, 32'h0, 32'h0, 1'b0);
    add_row(OP_LOAD, 32'h0, 32'h0, 32'h40000001, 32'h0, 1'b1, 32'h0, 32'h0, 32'h40000001);
    add_row(OP_MAP_PT, 32'h00010000, 32'h0, 32'h0, 32'h0, 1'b0);
    add_row(OP_LOAD, 32'h0, 32'h0, 32'hC0000000, 32'h0, 1'b1, 32'h0, 32'h0, 32'hC0000000);
    add_row(OP_MAP_TW, 32'h00010000, 32'h00020000, 32'h0, 32'h7FFFFFFF, 1'b0);
    add_row(OP_LOAD, 32'h0, 32'h0, 32'hBFFFFFFF, 32'h0, 1'b1, 32'h0, 32'h0, 32'hBFFFFFFF);
    add_row(OP_COMPOSE, 32'h00010000, 32'h0, 32'h80000000, 32'h0, 1'b0);
    add_row(OP_LOAD, 32'h0, 32'h0, 32'h80000000, 32'h0, 1'b1, 32'h0, 32'h0, 32'h80000000);
    add_row(OP_MAP_PT, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 32'h0, 1'b0);
    add_row(OP_LOAD, 32'h80000000, 32'h80000000, 32'h12345678, 32'h0, 1'b1,
            32'h80000000, 32'h80000000, 32'h12345678);
    add_row(OP_INVERSE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    add_row(OP_COMPOSE, 32'h80000000, 32'h80000000, 32'h0, 32'h0, 1'b0);
    add_row(OpUnusedHi, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    add_row(OP_INVERSE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);

    trk_x = 0;
    trk_y = 0;
    trk_heading = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (cmd_table[i]) send_cmd(cmd_table[i]);

    for (int n = 0; n < RandomCmds; n++) begin
      // run two stretches at full rate on both sides
      steady_flow = (n >= 400 && n < 550) || (n >= 1100 && n < 1250);
      if (n == 800) begin
        // drain: hold off until every answer is back
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge clk_i);
      end
      r.op = pick_op();
      r.x = pick_coord();
      r.y = pick_coord();
      r.angle = pick_angle();
      r.rate = $urandom;
      r.typed = 1'b0;
      send_cmd(r);
    end
    s_axis_tvalid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (CordicSteps + 8) @(posedge clk_i);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
